[rtl/led_breathing_level_generator_defines.svh]
// Assertion macros used by the RTL of the breathing level generator.
// Define ASSERT_OFF to compile the checks away.
`ifndef LED_BREATHING_LEVEL_GENERATOR_DEFINES_SVH
`define LED_BREATHING_LEVEL_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled at the rising clock edge.
`define LBL_ASSERT_IMPL(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled at the rising clock edge.
`define LBL_ASSERT_NEXT(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`else

`define LBL_ASSERT_IMPL(label, clock, reset, cond, expr)
`define LBL_ASSERT_NEXT(label, clock, reset, cond, expr)

`endif

`endif

[rtl/lbl_pkg.sv]
`default_nettype none

package lbl_pkg;

  // Default breath table size, as a number of index bits.
  localparam int unsigned TABLE_INDEX_BITS_DEF = 10;

  // Field and register widths.
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned ENTRY_W  = 17;
  localparam int unsigned CNT_W    = 6;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_BLINK_MODE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_BASE_PERIOD = 3'd1;
  localparam logic [IDX_W-1:0] REG_SPEED       = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOW_LEVEL   = 3'd3;
  localparam logic [IDX_W-1:0] REG_HIGH_LEVEL  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SOLID_LEVEL = 3'd5;

  // Output modes.
  typedef enum logic [1:0] {
    MODE_BREATHE = 2'd0,
    MODE_FLASH   = 2'd1,
    MODE_STEADY  = 2'd2,
    MODE_DARK    = 2'd3
  } mode_t;

  // Fixed-point constants of the table build, Q4.28.
  localparam longint unsigned FX_SHIFT  = 28;
  localparam longint unsigned FX_ONE    = 64'd1 << FX_SHIFT;
  localparam longint unsigned FX_PI     = 64'd843314857;
  localparam longint unsigned FX_INV_E  = (64'd36787944 << FX_SHIFT) / 64'd100000000;
  localparam longint unsigned FX_SPAN   = (64'd235040238 << FX_SHIFT) / 64'd100000000;
  localparam longint unsigned Q16_ONE   = 64'd65536;

  // Taylor divisors of the cosine, from the innermost term out.
  function automatic longint unsigned cos_div(input int unsigned k);
    longint unsigned r;
    case (k)
      0:       r = 64'd132;
      1:       r = 64'd90;
      2:       r = 64'd56;
      3:       r = 64'd30;
      4:       r = 64'd12;
      default: r = 64'd2;
    endcase
    return r;
  endfunction

  // Quotient by shift and subtract, one bit per step; used only for the table build.
  function automatic longint unsigned cdiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q, r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // One breath table entry in Q1.16, evaluated at elaboration only.
  function automatic logic [ENTRY_W-1:0] breath_entry(input int unsigned bits,
                                                     input int unsigned i);
    longint unsigned n, ii, v, w, x, x2, t, d, a, ex, e;
    bit cos_neg;
    n  = 64'd1 << bits;
    ii = 64'(i);
    v  = (ii <= (n >> 1)) ? ii : (n - ii);
    cos_neg = (v > (n >> 2));
    w  = cos_neg ? ((n >> 1) - v) : v;
    x  = (64'd2 * FX_PI * w) >> bits;
    x2 = (x * x) >> FX_SHIFT;
    // Cosine of the folded quarter-turn angle.
    t = FX_ONE;
    for (int k = 0; k < 6; k++) begin
      d = cdiv((x2 * t) >> FX_SHIFT, cos_div(k));
      t = (d < FX_ONE) ? (FX_ONE - d) : 64'd0;
    end
    // Exponential of the cosine magnitude.
    a = t;
    t = FX_ONE;
    for (int nn = 12; nn >= 1; nn--) begin
      t = FX_ONE + cdiv((a * t) >> FX_SHIFT, 64'(nn));
    end
    ex = cos_neg ? t : cdiv(FX_ONE << FX_SHIFT, t);
    // Normalize into [0, 1] and saturate.
    e = 64'd0;
    if (ex > FX_INV_E) begin
      e = cdiv((ex - FX_INV_E) << 16, FX_SPAN);
    end
    if (e > Q16_ONE) begin
      e = Q16_ONE;
    end
    return ENTRY_W'(e);
  endfunction

endpackage

`default_nettype wire

[rtl/led_breathing_level_generator.sv]
// LED breathing level generator.
// Each beat on the slave channel (s_tdata) carries a free-running millisecond
// timestamp. For each one the block returns one beat on the master channel:
// the LED duty level in m_tdata and, in m_tuser, a flag that is set when the
// level differs from the previous one (or is the first since reset).
// The cfg_we/cfg_index/cfg_data port writes the mode, period, speed and levels;
// write it only while no beat is in flight.
// One shared restoring divider, one quotient bit per cycle, does all the work:
// it divides for the effective period and for the time within the period and,
// in breath mode only, for the breath table index, which is followed by a
// table read and a multiply. A beat must leave the sequencer before the next
// beat can be taken; s_tready is high only while the sequencer is idle.
// The result waits in an output register; a stalled receiver holds it, and a
// finished result that cannot leave stops the sequencer until it is taken.
// Reset (synchronous, active high) restores the default registers and forgets
// the previous level, so the first result after reset is always flagged.
`default_nettype none
`include "led_breathing_level_generator_defines.svh"

module led_breathing_level_generator #(
  parameter int unsigned TABLE_INDEX_BITS = lbl_pkg::TABLE_INDEX_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Slave channel. s_tdata: time_ms [31:0].
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [lbl_pkg::TIME_W-1:0]   s_tdata,
  // Master channel. m_tdata: level [7:0]. m_tuser: changed [0].
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [lbl_pkg::LEVEL_W-1:0]       m_tdata,
  output logic [0:0]                        m_tuser,
  // Configuration write port.
  input  wire logic                         cfg_we,
  input  wire logic [lbl_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [lbl_pkg::CFG_W-1:0]    cfg_data
);

  localparam int unsigned TBL_N = 1 << TABLE_INDEX_BITS;
  localparam int unsigned TW    = lbl_pkg::TIME_W;
  localparam int unsigned LW    = lbl_pkg::LEVEL_W;
  localparam int unsigned EW    = lbl_pkg::ENTRY_W;
  localparam int unsigned PW    = EW + LW;
  localparam int unsigned CW    = lbl_pkg::CNT_W;
  localparam int unsigned SPEED_W_LOCAL = lbl_pkg::SPEED_W;

  typedef logic [EW-1:0] rom_t [TBL_N];

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PER    = 9'b000000010,
    S_MODSET = 9'b000000100,
    S_MOD    = 9'b000001000,
    S_IDXSET = 9'b000010000,
    S_IDX    = 9'b000100000,
    S_ROM    = 9'b001000000,
    S_MUL    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < TBL_N; i++) begin
      r[i] = lbl_pkg::breath_entry(TABLE_INDEX_BITS, i);
    end
    return r;
  endfunction

  localparam rom_t BREATH_ROM = build_rom();

  // Configuration registers.
  lbl_pkg::mode_t                   blink_mode;
  logic [lbl_pkg::PERIOD_W-1:0]     base_period_ms;
  logic [lbl_pkg::SPEED_W-1:0]      speed_q8_8;
  logic [LW-1:0]                    low_level;
  logic [LW-1:0]                    high_level;
  logic [LW-1:0]                    solid_level;

  // Sequencer and datapath registers.
  state_t          state;
  logic [CW-1:0]   cnt;
  logic [TW-1:0]   rem;
  logic [TW-1:0]   dq;
  logic [TW-1:0]   dvsr;
  logic [TW-1:0]   per;
  logic [TW-1:0]   time_q;
  logic            first_half;
  logic [EW-1:0]   rom_q;
  logic [PW-1:0]   prod;
  logic [LW-1:0]   prev_level;
  logic            prev_valid;
  logic            out_valid;
  logic [LW-1:0]   out_level;
  logic            out_changed;

  // Combinational signals.
  logic [TW:0]     trial;
  logic            take;
  logic [TW-1:0]   rem_step;
  logic [TW-1:0]   dq_step;
  logic [TW-1:0]   per_next;
  logic [SPEED_W_LOCAL-1:0] spd;
  logic [LW-1:0]   lo;
  logic [LW-1:0]   hi;
  logic [LW-1:0]   level_next;
  logic            div_busy;
  logic            load_out;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_mode     <= lbl_pkg::MODE_BREATHE;
      base_period_ms <= 24'd2000;
      speed_q8_8     <= 16'd256;
      low_level      <= 8'd0;
      high_level     <= 8'd255;
      solid_level    <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        lbl_pkg::REG_BLINK_MODE:  blink_mode     <= lbl_pkg::mode_t'(cfg_data[1:0]);
        lbl_pkg::REG_BASE_PERIOD: base_period_ms <= cfg_data[lbl_pkg::PERIOD_W-1:0];
        lbl_pkg::REG_SPEED:       speed_q8_8     <= cfg_data[lbl_pkg::SPEED_W-1:0];
        lbl_pkg::REG_LOW_LEVEL:   low_level      <= cfg_data[LW-1:0];
        lbl_pkg::REG_HIGH_LEVEL:  high_level     <= cfg_data[LW-1:0];
        lbl_pkg::REG_SOLID_LEVEL: solid_level    <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // One restoring division step, shared by the three divisions.
  always_comb begin
    trial    = {rem, dq[TW-1]};
    take     = (trial >= {1'b0, dvsr});
    rem_step = take ? TW'(trial - {1'b0, dvsr}) : trial[TW-1:0];
    dq_step  = {dq[TW-2:0], take};
  end

  assign spd      = (speed_q8_8 == '0) ? SPEED_W_LOCAL'(1) : speed_q8_8;
  assign per_next = (dq == '0) ? TW'(1) : dq;
  assign div_busy = (state == S_PER) || (state == S_MOD) || (state == S_IDX);
  assign load_out = (state == S_DONE) && (!out_valid || m_tready);

  // Level selection from the finished datapath results.
  always_comb begin
    lo = (low_level > high_level) ? high_level : low_level;
    hi = (low_level > high_level) ? low_level : high_level;
    case (blink_mode)
      lbl_pkg::MODE_BREATHE: level_next = lo + prod[PW-2 -: LW];
      lbl_pkg::MODE_FLASH:   level_next = first_half ? hi : lo;
      lbl_pkg::MODE_STEADY: begin
        if (solid_level < lo) begin
          level_next = lo;
        end else if (solid_level > hi) begin
          level_next = hi;
        end else begin
          level_next = solid_level;
        end
      end
      default:               level_next = '0;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_PER;
            cnt   <= CW'(TW);
          end
        end
        S_PER: begin
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_MODSET;
          end
        end
        S_MODSET: begin
          state <= S_MOD;
          cnt   <= CW'(TW);
        end
        S_MOD: begin
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_IDXSET;
          end
        end
        S_IDXSET: begin
          if (blink_mode == lbl_pkg::MODE_BREATHE) begin
            state <= S_IDX;
            cnt   <= CW'(TABLE_INDEX_BITS);
          end else begin
            state <= S_DONE;
          end
        end
        S_IDX: begin
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_ROM;
          end
        end
        S_ROM:  state <= S_MUL;
        S_MUL:  state <= S_DONE;
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Divider datapath and intermediate results.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        time_q <= s_tdata;
        rem    <= '0;
        dq     <= {base_period_ms, 8'd0};
        dvsr   <= TW'(spd);
      end
      S_MODSET: begin
        per  <= per_next;
        dvsr <= per_next;
        rem  <= '0;
        dq   <= time_q;
      end
      S_IDXSET: begin
        // The remainder is the time within the period; the index division
        // continues from it with zero dividend bits.
        first_half <= ({rem, 1'b0} < {1'b0, per});
        dq         <= '0;
      end
      default: begin
        if (div_busy) begin
          rem <= rem_step;
          dq  <= dq_step;
        end
      end
    endcase
  end

  // Breath table read and scaling by the level span.
  always_ff @(posedge clk) begin
    rom_q <= BREATH_ROM[dq[TABLE_INDEX_BITS-1:0]];
    if (state == S_MUL) begin
      prod <= PW'(rom_q) * PW'(hi - lo);
    end
  end

  // Output register and change tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prev_level <= '0;
      prev_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid  <= 1'b1;
        prev_level <= level_next;
        prev_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_level   <= level_next;
      out_changed <= !prev_valid || (level_next != prev_level);
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_level;
  assign m_tuser  = out_changed;

  // The partial remainder always stays below the divisor while dividing.
  `LBL_ASSERT_IMPL(a_rem_below_divisor, clk, rst, div_busy, (rem < dvsr))
  // The table index division never produces quotient bits above the index.
  `LBL_ASSERT_IMPL(a_index_in_range, clk, rst, (state == S_ROM), ((dq >> TABLE_INDEX_BITS) == '0))
  // A finished result reaches the output whenever the output is free.
  `LBL_ASSERT_NEXT(a_result_loaded, clk, rst, ((state == S_DONE) && !out_valid), (m_tvalid && s_tready))

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

  import lbl_pkg::*;

  localparam int unsigned CURVE_BITS   = TABLE_INDEX_BITS_DEF;
  localparam int unsigned CURVE_N      = 1 << CURVE_BITS;
  localparam int unsigned SEGMENTS     = 12;
  localparam int unsigned SEG_ITEMS    = 170;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned TAIL_CYCLES  = 100;
  localparam int unsigned QUIET_LIMIT  = 5000;

  // Register indexes that map to nothing in the block.
  localparam logic [IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

  // Fixed-point constants of the breath curve, Q4.28.
  localparam int unsigned      Q28_BITS  = 28;
  localparam longint unsigned  Q28_ONE   = 64'd1 << Q28_BITS;
  localparam longint unsigned  PI_Q28    = 64'd843314857;
  localparam longint unsigned  INV_E_Q28 = (64'd36787944 << Q28_BITS) / 64'd100000000;
  localparam longint unsigned  SPAN_Q28  = (64'd235040238 << Q28_BITS) / 64'd100000000;
  localparam longint unsigned  ENTRY_MAX = 64'd65536;

  // An expected result beat.
  typedef struct packed {
    logic [LEVEL_W-1:0] lvl;
    logic               chg;
  } level_beat_t;

  // A level typed in by hand for one input beat, used instead of the prediction.
  typedef struct packed {
    bit                 fixed;
    logic [LEVEL_W-1:0] lvl;
    logic               chg;
  } pin_t;

  typedef enum logic [0:0] {ROW_WRITE, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [CFG_W-1:0]   data;
    logic [TIME_W-1:0]  stamp;
    pin_t               pin;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TIME_W-1:0]  s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [LEVEL_W-1:0] m_tdata;
  logic [0:0]         m_tuser;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  // Shadow copy of the registers and of the last level given.
  mode_t               mode_r;
  logic [PERIOD_W-1:0] base_r;
  logic [SPEED_W-1:0]  speed_r;
  logic [LEVEL_W-1:0]  low_r;
  logic [LEVEL_W-1:0]  high_r;
  logic [LEVEL_W-1:0]  solid_r;
  logic [LEVEL_W-1:0]  last_level;
  bit                  last_valid;

  int unsigned curve [CURVE_N];
  level_beat_t expected_levels[$];
  pin_t        stamp_pins[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_pending   = 1'b0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  always #5 clk = ~clk;

  led_breathing_level_generator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // One entry of the breath curve: (exp(-cos(2*pi*i/N)) - 1/e) / (e - 1/e) in Q1.16.
  function automatic int unsigned curve_entry(input int unsigned i);
    longint unsigned fold, quarter, ang, sq, c, d, ex, ev;
    bit far_half;
    int n;
    fold     = (i <= CURVE_N / 2) ? i : CURVE_N - i;
    far_half = fold > CURVE_N / 4;
    quarter  = far_half ? CURVE_N / 2 - fold : fold;
    ang      = (2 * PI_Q28 * quarter) >> CURVE_BITS;
    sq       = (ang * ang) >> Q28_BITS;
    // Cosine by Horner; the divisors are n*(n+1) for n = 11, 9, ..., 1.
    c = Q28_ONE;
    for (n = 11; n >= 1; n = n - 2) begin
      d = ((sq * c) >> Q28_BITS) / longint'(n * (n + 1));
      c = (d < Q28_ONE) ? Q28_ONE - d : 64'd0;
    end
    // Exponential of the cosine magnitude; the near half takes the reciprocal.
    ex = Q28_ONE;
    for (n = 12; n >= 1; n--) begin
      ex = Q28_ONE + ((c * ex) >> Q28_BITS) / longint'(n);
    end
    if (!far_half) begin
      ex = (Q28_ONE << Q28_BITS) / ex;
    end
    ev = 0;
    if (ex > INV_E_Q28) begin
      ev = ((ex - INV_E_Q28) << 16) / SPAN_Q28;
    end
    if (ev > ENTRY_MAX) begin
      ev = ENTRY_MAX;
    end
    return 32'(ev);
  endfunction

  // Level for a timestamp under the current shadow registers.
  function automatic logic [LEVEL_W-1:0] predict_level(input logic [TIME_W-1:0] stamp);
    longint unsigned spd, per, ph, idx, span, b;
    int unsigned lo, hi, tmp, lvl;
    spd = (speed_r == 0) ? 64'd1 : speed_r;
    b   = base_r;
    per = (b << 8) / spd;
    if (per == 0) begin
      per = 1;
    end
    ph = {32'd0, stamp} % per;
    lo = low_r;
    hi = high_r;
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    case (mode_r)
      MODE_BREATHE: begin
        idx  = ((ph << CURVE_BITS) / per) & (CURVE_N - 1);
        span = hi - lo;
        lvl  = lo + 32'((curve[idx] * span) >> 16);
      end
      MODE_FLASH: begin
        lvl = (2 * ph < per) ? hi : lo;
      end
      MODE_STEADY: begin
        lvl = solid_r;
        if (lvl < lo) lvl = lo;
        if (lvl > hi) lvl = hi;
      end
      default: begin
        lvl = 0;
      end
    endcase
    return lvl[LEVEL_W-1:0];
  endfunction

  function automatic plan_row_t beat_row(input logic [TIME_W-1:0] stamp);
    plan_row_t row;
    row.kind      = ROW_BEAT;
    row.idx       = '0;
    row.data      = '0;
    row.stamp     = stamp;
    row.pin       = '0;
    return row;
  endfunction

  function automatic plan_row_t pinned_row(input logic [TIME_W-1:0] stamp,
                                           input logic [LEVEL_W-1:0] lvl,
                                           input logic chg);
    plan_row_t row;
    row           = beat_row(stamp);
    row.pin.fixed = 1'b1;
    row.pin.lvl   = lvl;
    row.pin.chg   = chg;
    return row;
  endfunction

  function automatic plan_row_t write_row(input logic [IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
    plan_row_t row;
    row      = beat_row('0);
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  // Offer one timestamp beat, after a random gap, and wait until it is taken.
  task automatic offer_beat(input logic [TIME_W-1:0] stamp, input pin_t pin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    stamp_pins.push_back(pin);
    s_tvalid <= 1'b1;
    s_tdata  <= stamp;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending and wait until every expected level has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_levels.size() != 0 || !s_tready);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // New register settings for one random segment; junk fills the unused upper bits.
  task automatic configure_segment(input int unsigned seg);
    logic [CFG_W-1:0]    junk;
    mode_t               m;
    logic [PERIOD_W-1:0] base;
    logic [SPEED_W-1:0]  spd;
    logic [LEVEL_W-1:0]  lo, hi;
    junk = CFG_W'($urandom);
    if (seg < 4) begin
      m = mode_t'(seg);
    end else if (seg == 4) begin
      m = MODE_BREATHE;
    end else begin
      m = mode_t'($urandom_range(0, 3));
    end
    case (seg)
      4:       base = 24'hFF_FFFF;
      5:       base = 24'd1;
      default: base = ($urandom_range(0, 3) == 0) ? PERIOD_W'($urandom_range(1, 24'hFF_FFFF))
                                                  : PERIOD_W'($urandom_range(1, 3000));
    endcase
    case (seg)
      4:       spd = 16'd1;
      5:       spd = 16'hFFFF;
      6:       spd = 16'd0;
      default: begin
        case ($urandom_range(0, 2))
          0:       spd = 16'd256;
          1:       spd = SPEED_W'($urandom_range(1, 65535));
          default: spd = SPEED_W'($urandom_range(64, 1024));
        endcase
      end
    endcase
    case (seg)
      7:       begin lo = 8'd0;   hi = 8'd255; end
      8:       begin lo = 8'd255; hi = 8'd0;   end
      default: begin lo = LEVEL_W'($urandom); hi = LEVEL_W'($urandom); end
    endcase
    write_reg(REG_BLINK_MODE,  {junk[23:2], m});
    write_reg(REG_BASE_PERIOD, base);
    write_reg(REG_SPEED,       {junk[7:0], spd});
    write_reg(REG_LOW_LEVEL,   {junk[15:0], lo});
    write_reg(REG_HIGH_LEVEL,  {junk[23:8], hi});
    write_reg(REG_SOLID_LEVEL, CFG_W'($urandom));
  endtask

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Track register writes, predict each accepted timestamp and check each level beat.
  always @(posedge clk) begin : monitor
    level_beat_t want;
    pin_t        pin;
    logic [LEVEL_W-1:0] lvl;
    bit          moved;
    moved = 1'b0;
    if (rst) begin
      base_r     = 24'd2000;
      speed_r    = 16'd256;
      low_r      = 8'd0;
      high_r     = 8'd255;
      solid_r    = 8'd128;
      last_level = '0;
      last_valid = 1'b0;
      mode_r     = MODE_BREATHE;
    end else begin
      if (cfg_we) begin
        moved = 1'b1;
        case (cfg_index)
          REG_BLINK_MODE:  mode_r  = mode_t'(cfg_data[1:0]);
          REG_BASE_PERIOD: base_r  = cfg_data[PERIOD_W-1:0];
          REG_SPEED:       speed_r = cfg_data[SPEED_W-1:0];
          REG_LOW_LEVEL:   low_r   = cfg_data[LEVEL_W-1:0];
          REG_HIGH_LEVEL:  high_r  = cfg_data[LEVEL_W-1:0];
          REG_SOLID_LEVEL: solid_r = cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        pin   = stamp_pins.pop_front();
        lvl   = predict_level(s_tdata);
        want.lvl = lvl;
        want.chg = !last_valid || lvl != last_level;
        if (pin.fixed) begin
          want.lvl = pin.lvl;
          want.chg = pin.chg;
        end
        expected_levels.push_back(want);
        last_level = lvl;
        last_valid = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        if (expected_levels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: level beat with nothing expected: level %0d changed %0d",
                     $time, m_tdata, m_tuser[0]);
          end
        end else begin
          want = expected_levels.pop_front();
          if (m_tdata !== want.lvl || m_tuser[0] !== want.chg) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected level %0d changed %0d, got level %0d changed %0d",
                       $time, want.lvl, want.chg, m_tdata, m_tuser[0]);
            end
          end
        end
      end
    end
    // Watchdog on cycles without any handshake or write.
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL led_breathing_level_generator");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t         plan[$];
    logic [TIME_W-1:0] stamp;
    int unsigned       seg, k, i;
    int unsigned       r;

    for (i = 0; i < CURVE_N; i++) begin
      curve[i] = curve_entry(i);
    end

    // Directed rows: reset defaults, every mode, swapped levels, wide and stray writes,
    // zero speed and zero period.
    plan.push_back(beat_row(32'd0));
    plan.push_back(beat_row(32'hFFFF_FFFF));
    plan.push_back(beat_row(32'd1000));
    plan.push_back(beat_row(32'd500));
    plan.push_back(write_row(REG_BLINK_MODE, {22'd0, MODE_DARK}));
    plan.push_back(pinned_row(32'd12345, 8'd0, 1'b1));
    plan.push_back(pinned_row(32'd7, 8'd0, 1'b0));
    plan.push_back(write_row(REG_BASE_PERIOD, 24'd100));
    plan.push_back(write_row(REG_BLINK_MODE, {22'd0, MODE_FLASH}));
    plan.push_back(pinned_row(32'd0, 8'd255, 1'b1));
    plan.push_back(pinned_row(32'd49, 8'd255, 1'b0));
    plan.push_back(pinned_row(32'd50, 8'd0, 1'b1));
    plan.push_back(write_row(REG_LOW_LEVEL, 24'd200));
    plan.push_back(write_row(REG_HIGH_LEVEL, 24'd10));
    plan.push_back(pinned_row(32'd99, 8'd10, 1'b1));
    plan.push_back(pinned_row(32'd100, 8'd200, 1'b1));
    plan.push_back(write_row(REG_BLINK_MODE, {22'h3F_FFFF, MODE_STEADY}));
    plan.push_back(pinned_row(32'd5, 8'd128, 1'b1));
    plan.push_back(write_row(REG_UNMAPPED_A, 24'hFF_FFFF));
    plan.push_back(write_row(REG_UNMAPPED_B, 24'h00_0000));
    plan.push_back(pinned_row(32'd8, 8'd128, 1'b0));
    plan.push_back(write_row(REG_SOLID_LEVEL, 24'h00_FF03));
    plan.push_back(pinned_row(32'd6, 8'd10, 1'b1));
    plan.push_back(write_row(REG_SPEED, 24'd0));
    plan.push_back(write_row(REG_BLINK_MODE, {22'd0, MODE_BREATHE}));
    plan.push_back(beat_row(32'd12800));
    plan.push_back(write_row(REG_BASE_PERIOD, 24'd0));
    plan.push_back(beat_row(32'h8000_0000));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[p]) begin
      if (plan[p].kind == ROW_WRITE) begin
        write_reg(plan[p].idx, plan[p].data);
      end else begin
        offer_beat(plan[p].stamp, plan[p].pin);
      end
    end

    // Random segments, each under new settings and one of four idling patterns.
    stamp = $urandom;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      configure_segment(seg);
      case (seg % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      for (k = 0; k < SEG_ITEMS; k++) begin
        if (seg == 4 && k == 40) begin
          hold_pending = 1'b1;
        end
        if (k == SEG_ITEMS / 2) begin
          settle();
        end
        // Mostly ticking timestamps with log-spread steps, some jumps, some near the wrap.
        r = $urandom_range(0, 99);
        if (r < 60) begin
          stamp = stamp + $urandom_range(0, 1 << $urandom_range(0, 16));
        end else if (r < 90) begin
          stamp = $urandom;
        end else begin
          stamp = 32'hFFFF_FFFF - $urandom_range(0, 15);
        end
        offer_beat(stamp, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS led_breathing_level_generator");
    end else begin
      $display("FAIL led_breathing_level_generator");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/lbl_pkg.sv
rtl/led_breathing_level_generator.sv
sim/tb.sv
